@@ hdl/csp_pkg.sv @@
// Shared constants, types and widths for the capacitive slider position block.
package csp_pkg;

    // Slider geometry and count width.
    localparam int NUM_PADS   = 4;
    localparam int COUNT_BITS = 16;

    // Normalized pad levels run 0..256 and need 9 bits.
    localparam int LVL_SHIFT = 8;
    localparam int LVL_W     = LVL_SHIFT + 1;
    localparam int THR_W     = 9;

    localparam logic [LVL_W-1:0] LEVEL_FULL   = LVL_W'(256);
    localparam logic [LVL_W-1:0] EDGE_LEVEL   = LVL_W'(255);
    localparam logic [THR_W-1:0] THRESH_RESET = THR_W'(236);

    // Level divider: one quotient bit per stage. The quotient is known to stay
    // below 2^LVL_STEPS once the saturation check has passed.
    localparam int LVL_STEPS = LVL_SHIFT + 1;
    localparam int REM_W     = COUNT_BITS + LVL_STEPS;
    localparam int LANE_LAT  = LVL_STEPS + 1;

    // Interpolation terms: numerator is (256 - level) << 3, quotient at most 8.
    localparam int NUM_SHIFT  = 3;
    localparam int NUM_W      = LVL_W + NUM_SHIFT;
    localparam int TERM_W     = NUM_SHIFT + 1;
    localparam int TERM_STEPS = TERM_W;
    localparam int INTERP_LAT = TERM_STEPS + 1;

    // Pad pitch is 16 position units.
    localparam int PAD_SHIFT = 4;
    localparam int PICK_W    = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;
    localparam int RAW_W     = PICK_W + PAD_SHIFT + 1;
    localparam int POS_W     = 6;
    localparam int POS_TOP   = (NUM_PADS - 1) * 16;

    // Whole pipeline from input register to result register.
    localparam int MERGE_LAT = 1;
    localparam int PIPE_LAT  = LANE_LAT + MERGE_LAT + INTERP_LAT;

    // Result queue.
    localparam int FIFO_DEPTH = 32;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    typedef logic [LVL_W-1:0] t_level;

    // Handoff from the merging stage to the interpolation divider.
    typedef struct packed {
        logic              hit;
        logic [PICK_W-1:0] pick;
        logic [LVL_W-1:0]  den;
        logic [NUM_W-1:0]  lo_num;
        logic [NUM_W-1:0]  hi_num;
    } t_merge;

    // One finished result.
    typedef struct packed {
        logic             touched;
        logic [POS_W-1:0] position;
    } t_result;

endpackage

@@ hdl/csp_ifs.sv @@
// Valid/ready channel interfaces for the scan input and the position output.
interface csp_in_if;
    logic                           valid;
    logic                           ready;
    logic [csp_pkg::COUNT_BITS-1:0] pad0_count;
    logic [csp_pkg::COUNT_BITS-1:0] pad1_count;
    logic [csp_pkg::COUNT_BITS-1:0] pad2_count;
    logic [csp_pkg::COUNT_BITS-1:0] pad3_count;
    logic [csp_pkg::COUNT_BITS-1:0] pad0_max;
    logic [csp_pkg::COUNT_BITS-1:0] pad1_max;
    logic [csp_pkg::COUNT_BITS-1:0] pad2_max;
    logic [csp_pkg::COUNT_BITS-1:0] pad3_max;

    modport source (
        output valid, pad0_count, pad1_count, pad2_count, pad3_count,
               pad0_max, pad1_max, pad2_max, pad3_max,
        input  ready
    );
    modport sink (
        input  valid, pad0_count, pad1_count, pad2_count, pad3_count,
               pad0_max, pad1_max, pad2_max, pad3_max,
        output ready
    );
endinterface

interface csp_out_if;
    logic                      valid;
    logic                      ready;
    logic                      touched;
    logic [csp_pkg::POS_W-1:0] position;

    modport source (output valid, touched, position, input ready);
    modport sink   (input valid, touched, position, output ready);
endinterface

@@ hdl/csp_level_lane.sv @@
// One pad lane: pipelined restoring divider giving the normalized pad level.
module csp_level_lane (
    input  logic                           i_clk,
    input  logic [csp_pkg::COUNT_BITS-1:0] i_count,
    input  logic [csp_pkg::COUNT_BITS-1:0] i_max,
    output csp_pkg::t_level                o_level
);

    logic [csp_pkg::REM_W-1:0]      r_rem [csp_pkg::LVL_STEPS];
    logic [csp_pkg::REM_W-1:0]      n_rem [csp_pkg::LVL_STEPS];
    logic [csp_pkg::COUNT_BITS-1:0] r_div [csp_pkg::LVL_STEPS];
    logic [csp_pkg::COUNT_BITS-1:0] n_div [csp_pkg::LVL_STEPS];
    logic [csp_pkg::LVL_W-1:0]      r_q   [csp_pkg::LVL_STEPS];
    logic [csp_pkg::LVL_W-1:0]      n_q   [csp_pkg::LVL_STEPS];
    logic                           r_sat [csp_pkg::LVL_STEPS];
    logic                           n_sat [csp_pkg::LVL_STEPS];
    csp_pkg::t_level                r_level;
    csp_pkg::t_level                n_level;

    // Entry stage flags a zero max or a quotient that is sure to exceed full
    // scale (count at least twice max); every later stage retires one bit.
    always_comb begin
        logic [csp_pkg::REM_W-1:0] sh;
        logic [csp_pkg::REM_W-1:0] rem;
        logic [csp_pkg::LVL_W-1:0] q;
        logic                      take;

        n_rem[0] = csp_pkg::REM_W'(i_count) << csp_pkg::LVL_SHIFT;
        n_div[0] = i_max;
        n_q[0]   = '0;
        n_sat[0] = (i_max == '0) || ({1'b0, i_count} >= {i_max, 1'b0});

        for (int s = 1; s < csp_pkg::LVL_STEPS; s++) begin
            sh       = csp_pkg::REM_W'(r_div[s-1]) << (csp_pkg::LVL_STEPS - s);
            take     = (r_rem[s-1] >= sh);
            n_rem[s] = take ? (r_rem[s-1] - sh) : r_rem[s-1];
            n_div[s] = r_div[s-1];
            n_q[s]   = {r_q[s-1][csp_pkg::LVL_W-2:0], take};
            n_sat[s] = r_sat[s-1];
        end

        // Last quotient bit, then clamp to full scale.
        rem  = r_rem[csp_pkg::LVL_STEPS-1];
        sh   = csp_pkg::REM_W'(r_div[csp_pkg::LVL_STEPS-1]);
        take = (rem >= sh);
        q    = {r_q[csp_pkg::LVL_STEPS-1][csp_pkg::LVL_W-2:0], take};
        if (r_sat[csp_pkg::LVL_STEPS-1] || (q > csp_pkg::LEVEL_FULL)) begin
            n_level = csp_pkg::LEVEL_FULL;
        end else begin
            n_level = q;
        end
    end

    // Stage registers carry payload only; validity is tracked at the top level.
    always_ff @(posedge i_clk) begin
        for (int s = 0; s < csp_pkg::LVL_STEPS; s++) begin
            r_rem[s] <= n_rem[s];
            r_div[s] <= n_div[s];
            r_q[s]   <= n_q[s];
            r_sat[s] <= n_sat[s];
        end
        r_level <= n_level;
    end

    assign o_level = r_level;

endmodule

@@ hdl/csp_merge.sv @@
// Merging stage: picks the touched pad and forms the interpolation operands.
module csp_merge (
    input  logic                      i_clk,
    input  csp_pkg::t_level           i_level [csp_pkg::NUM_PADS],
    input  logic [csp_pkg::THR_W-1:0] i_thr,
    output csp_pkg::t_merge           o_merge
);

    csp_pkg::t_merge r_merge;
    csp_pkg::t_merge n_merge;

    // First pad with the strictly lowest level under the threshold wins.
    always_comb begin
        csp_pkg::t_level             lv_ext [csp_pkg::NUM_PADS + 2];
        csp_pkg::t_level             best;
        csp_pkg::t_level             left;
        csp_pkg::t_level             right;
        logic [csp_pkg::LVL_W-1:0]   lo_diff;
        logic [csp_pkg::LVL_W-1:0]   hi_diff;
        logic                        hit;
        logic [csp_pkg::PICK_W-1:0]  pick;

        // Virtual pads beyond both ends read just under full scale.
        lv_ext[0]                     = csp_pkg::EDGE_LEVEL;
        lv_ext[csp_pkg::NUM_PADS + 1] = csp_pkg::EDGE_LEVEL;
        for (int i = 0; i < csp_pkg::NUM_PADS; i++) begin
            lv_ext[i+1] = i_level[i];
        end

        if (i_thr > csp_pkg::THR_W'(csp_pkg::LEVEL_FULL)) begin
            best = csp_pkg::LEVEL_FULL;
        end else begin
            best = csp_pkg::LVL_W'(i_thr);
        end
        hit   = 1'b0;
        pick  = '0;
        left  = csp_pkg::EDGE_LEVEL;
        right = csp_pkg::EDGE_LEVEL;

        for (int i = 0; i < csp_pkg::NUM_PADS; i++) begin
            if (lv_ext[i+1] < best) begin
                best  = lv_ext[i+1];
                hit   = 1'b1;
                pick  = csp_pkg::PICK_W'(i);
                left  = lv_ext[i];
                right = lv_ext[i+2];
            end
        end

        lo_diff        = csp_pkg::LEVEL_FULL - left;
        hi_diff        = csp_pkg::LEVEL_FULL - right;
        n_merge.hit    = hit;
        n_merge.pick   = pick;
        n_merge.den    = csp_pkg::LEVEL_FULL - best;
        n_merge.lo_num = {lo_diff, {csp_pkg::NUM_SHIFT{1'b0}}};
        n_merge.hi_num = {hi_diff, {csp_pkg::NUM_SHIFT{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        r_merge <= n_merge;
    end

    assign o_merge = r_merge;

endmodule

@@ hdl/csp_interp.sv @@
// Interpolation: pipelined division of both neighbor terms, then position clamp.
module csp_interp (
    input  logic             i_clk,
    input  csp_pkg::t_merge  i_merge,
    output csp_pkg::t_result o_result
);

    logic [csp_pkg::NUM_W-1:0]  r_lo_rem [csp_pkg::TERM_STEPS];
    logic [csp_pkg::NUM_W-1:0]  n_lo_rem [csp_pkg::TERM_STEPS];
    logic [csp_pkg::NUM_W-1:0]  r_hi_rem [csp_pkg::TERM_STEPS];
    logic [csp_pkg::NUM_W-1:0]  n_hi_rem [csp_pkg::TERM_STEPS];
    logic [csp_pkg::TERM_W-1:0] r_lo_q   [csp_pkg::TERM_STEPS];
    logic [csp_pkg::TERM_W-1:0] n_lo_q   [csp_pkg::TERM_STEPS];
    logic [csp_pkg::TERM_W-1:0] r_hi_q   [csp_pkg::TERM_STEPS];
    logic [csp_pkg::TERM_W-1:0] n_hi_q   [csp_pkg::TERM_STEPS];
    logic [csp_pkg::LVL_W-1:0]  r_den    [csp_pkg::TERM_STEPS];
    logic [csp_pkg::LVL_W-1:0]  n_den    [csp_pkg::TERM_STEPS];
    logic [csp_pkg::PICK_W-1:0] r_pick   [csp_pkg::TERM_STEPS];
    logic [csp_pkg::PICK_W-1:0] n_pick   [csp_pkg::TERM_STEPS];
    logic                       r_hit    [csp_pkg::TERM_STEPS];
    logic                       n_hit    [csp_pkg::TERM_STEPS];
    csp_pkg::t_result           r_result;
    csp_pkg::t_result           n_result;

    // Source of each stage: the merge register for the first, else the stage before.
    logic [csp_pkg::NUM_W-1:0]  src_lo_rem [csp_pkg::TERM_STEPS];
    logic [csp_pkg::NUM_W-1:0]  src_hi_rem [csp_pkg::TERM_STEPS];
    logic [csp_pkg::TERM_W-1:0] src_lo_q   [csp_pkg::TERM_STEPS];
    logic [csp_pkg::TERM_W-1:0] src_hi_q   [csp_pkg::TERM_STEPS];
    logic [csp_pkg::LVL_W-1:0]  src_den    [csp_pkg::TERM_STEPS];
    logic [csp_pkg::PICK_W-1:0] src_pick   [csp_pkg::TERM_STEPS];
    logic                       src_hit    [csp_pkg::TERM_STEPS];

    always_comb begin
        src_lo_rem[0] = i_merge.lo_num;
        src_hi_rem[0] = i_merge.hi_num;
        src_lo_q[0]   = '0;
        src_hi_q[0]   = '0;
        src_den[0]    = i_merge.den;
        src_pick[0]   = i_merge.pick;
        src_hit[0]    = i_merge.hit;
        for (int s = 1; s < csp_pkg::TERM_STEPS; s++) begin
            src_lo_rem[s] = r_lo_rem[s-1];
            src_hi_rem[s] = r_hi_rem[s-1];
            src_lo_q[s]   = r_lo_q[s-1];
            src_hi_q[s]   = r_hi_q[s-1];
            src_den[s]    = r_den[s-1];
            src_pick[s]   = r_pick[s-1];
            src_hit[s]    = r_hit[s-1];
        end
    end

    // One restoring step per stage for both terms; they share the divisor.
    always_comb begin
        logic [csp_pkg::NUM_W:0] sh;
        logic                    take_lo;
        logic                    take_hi;

        for (int s = 0; s < csp_pkg::TERM_STEPS; s++) begin
            sh       = (csp_pkg::NUM_W + 1)'(src_den[s]) << (csp_pkg::TERM_STEPS - 1 - s);
            take_lo  = ({1'b0, src_lo_rem[s]} >= sh);
            take_hi  = ({1'b0, src_hi_rem[s]} >= sh);
            n_lo_rem[s] = take_lo ? (src_lo_rem[s] - sh[csp_pkg::NUM_W-1:0]) : src_lo_rem[s];
            n_hi_rem[s] = take_hi ? (src_hi_rem[s] - sh[csp_pkg::NUM_W-1:0]) : src_hi_rem[s];
            n_lo_q[s]   = {src_lo_q[s][csp_pkg::TERM_W-2:0], take_lo};
            n_hi_q[s]   = {src_hi_q[s][csp_pkg::TERM_W-2:0], take_hi};
            n_den[s]    = src_den[s];
            n_pick[s]   = src_pick[s];
            n_hit[s]    = src_hit[s];
        end
    end

    // Position is pick * 16 - left term + right term, held to the slider range.
    always_comb begin
        logic [csp_pkg::RAW_W-1:0] base;
        logic [csp_pkg::RAW_W-1:0] sum;
        logic [csp_pkg::RAW_W-1:0] lo;
        logic [csp_pkg::RAW_W-1:0] raw;

        base = csp_pkg::RAW_W'({r_pick[csp_pkg::TERM_STEPS-1], {csp_pkg::PAD_SHIFT{1'b0}}});
        sum  = base + csp_pkg::RAW_W'(r_hi_q[csp_pkg::TERM_STEPS-1]);
        lo   = csp_pkg::RAW_W'(r_lo_q[csp_pkg::TERM_STEPS-1]);
        if (sum < lo) begin
            raw = '0;
        end else begin
            raw = sum - lo;
        end
        if (raw > csp_pkg::RAW_W'(csp_pkg::POS_TOP)) begin
            raw = csp_pkg::RAW_W'(csp_pkg::POS_TOP);
        end

        n_result.touched = r_hit[csp_pkg::TERM_STEPS-1];
        if (r_hit[csp_pkg::TERM_STEPS-1]) begin
            n_result.position = raw[csp_pkg::POS_W-1:0];
        end else begin
            n_result.position = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < csp_pkg::TERM_STEPS; s++) begin
            r_lo_rem[s] <= n_lo_rem[s];
            r_hi_rem[s] <= n_hi_rem[s];
            r_lo_q[s]   <= n_lo_q[s];
            r_hi_q[s]   <= n_hi_q[s];
            r_den[s]    <= n_den[s];
            r_pick[s]   <= n_pick[s];
            r_hit[s]    <= n_hit[s];
        end
        r_result <= n_result;
    end

    assign o_result = r_result;

endmodule

@@ hdl/csp_out_fifo.sv @@
// Result queue between the fixed-latency pipeline and the output channel.
module csp_out_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  csp_pkg::t_result i_wr_data,
    input  logic             i_rd_en,
    output logic             o_rd_valid,
    output csp_pkg::t_result o_rd_data
);

    csp_pkg::t_result            r_slot [csp_pkg::FIFO_DEPTH];
    logic [csp_pkg::FIFO_AW-1:0] r_wptr;
    logic [csp_pkg::FIFO_AW-1:0] n_wptr;
    logic [csp_pkg::FIFO_AW-1:0] r_rptr;
    logic [csp_pkg::FIFO_AW-1:0] n_rptr;
    logic [csp_pkg::FIFO_CW-1:0] r_count;
    logic [csp_pkg::FIFO_CW-1:0] n_count;

    // Pointer and fill bookkeeping.
    always_comb begin
        n_wptr  = i_wr_en ? (r_wptr + 1'b1) : r_wptr;
        n_rptr  = i_rd_en ? (r_rptr + 1'b1) : r_rptr;
        n_count = r_count + csp_pkg::FIFO_CW'(i_wr_en) - csp_pkg::FIFO_CW'(i_rd_en);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Storage slots hold payload only.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_slot[r_wptr] <= i_wr_data;
        end
    end

    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_slot[r_rptr];

endmodule

@@ hdl/cap_slider_position.sv @@
// Top level: four pad lanes, merging stage, interpolation divider and result queue.
// Each scan passes the pad lanes, the merging stage and the interpolation divider
// into the result register, then enters the result queue that offers it out.
// Throughput: one scan per cycle; the 16-stage pipeline never stalls and input
// ready is held by a 32-entry credit count on the result queue.
// Reset clears the pipeline valid chain, the queue and sets the threshold to 236.
module cap_slider_position (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    csp_in_if.sink                    i_scan,
    csp_out_if.source                 o_pos,
    input  logic                      i_cfg_wr_en,
    input  logic [csp_pkg::THR_W-1:0] i_cfg_wr_data
);

    logic [csp_pkg::THR_W-1:0]      r_thr;
    logic [csp_pkg::THR_W-1:0]      n_thr;
    logic [csp_pkg::PIPE_LAT-1:0]   r_vld;
    logic [csp_pkg::PIPE_LAT-1:0]   n_vld;
    logic [csp_pkg::FIFO_CW-1:0]    r_inflight;
    logic [csp_pkg::FIFO_CW-1:0]    n_inflight;
    logic                           accept;
    logic                           deliver;
    logic                           q_valid;
    logic [csp_pkg::COUNT_BITS-1:0] w_count [csp_pkg::NUM_PADS];
    logic [csp_pkg::COUNT_BITS-1:0] w_max   [csp_pkg::NUM_PADS];
    csp_pkg::t_level                w_level [csp_pkg::NUM_PADS];
    csp_pkg::t_merge                w_merge;
    csp_pkg::t_result               w_result;
    csp_pkg::t_result               q_data;

    // Scan fields in pad order.
    assign w_count[0] = i_scan.pad0_count;
    assign w_count[1] = i_scan.pad1_count;
    assign w_count[2] = i_scan.pad2_count;
    assign w_count[3] = i_scan.pad3_count;
    assign w_max[0]   = i_scan.pad0_max;
    assign w_max[1]   = i_scan.pad1_max;
    assign w_max[2]   = i_scan.pad2_max;
    assign w_max[3]   = i_scan.pad3_max;

    // Handshakes: accept while the queue still has a free credit.
    assign i_scan.ready = (r_inflight < csp_pkg::FIFO_CW'(csp_pkg::FIFO_DEPTH));
    assign accept       = i_scan.valid && i_scan.ready;
    assign deliver      = q_valid && o_pos.ready;

    // Threshold register, valid chain and credit count.
    always_comb begin
        n_thr      = i_cfg_wr_en ? i_cfg_wr_data : r_thr;
        n_vld      = {r_vld[csp_pkg::PIPE_LAT-2:0], accept};
        n_inflight = r_inflight + csp_pkg::FIFO_CW'(accept) - csp_pkg::FIFO_CW'(deliver);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= csp_pkg::THRESH_RESET;
            r_vld      <= '0;
            r_inflight <= '0;
        end else begin
            r_thr      <= n_thr;
            r_vld      <= n_vld;
            r_inflight <= n_inflight;
        end
    end

    // One normalizing divider lane per pad.
    for (genvar g = 0; g < csp_pkg::NUM_PADS; g++) begin : g_lane
        csp_level_lane u_lane (
            .i_clk   (i_clk),
            .i_count (w_count[g]),
            .i_max   (w_max[g]),
            .o_level (w_level[g])
        );
    end

    csp_merge u_merge (
        .i_clk   (i_clk),
        .i_level (w_level),
        .i_thr   (r_thr),
        .o_merge (w_merge)
    );

    csp_interp u_interp (
        .i_clk    (i_clk),
        .i_merge  (w_merge),
        .o_result (w_result)
    );

    csp_out_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (r_vld[csp_pkg::PIPE_LAT-1]),
        .i_wr_data  (w_result),
        .i_rd_en    (deliver),
        .o_rd_valid (q_valid),
        .o_rd_data  (q_data)
    );

    assign o_pos.valid    = q_valid;
    assign o_pos.touched  = q_data.touched;
    assign o_pos.position = q_data.position;

    // The credit count never exceeds the queue depth.
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= csp_pkg::FIFO_CW'(csp_pkg::FIFO_DEPTH))
        else $error("in-flight count exceeds result queue depth");

    // A transaction leaving the pipeline always has a credit behind it.
    a_write_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[csp_pkg::PIPE_LAT-1] |-> (r_inflight != '0))
        else $error("pipeline result without an outstanding transaction");

    // An offered result always belongs to an outstanding transaction.
    a_valid_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_valid |-> (r_inflight != '0))
        else $error("output valid with no transaction in flight");

    // Untouched results report position zero, touched ones stay in range.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_valid |-> ((!q_data.touched && (q_data.position == '0)) ||
                     (q_data.touched &&
                      (q_data.position <= csp_pkg::POS_W'(csp_pkg::POS_TOP)))))
        else $error("output position outside the slider range");

endmodule

@@ sim/tb_cap_slider_position.sv @@
// Self-checking testbench for the capacitive slider position block.
module tb_cap_slider_position;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FULL        = int'(csp_pkg::LEVEL_FULL);
    localparam int EDGE        = int'(csp_pkg::EDGE_LEVEL);
    localparam int SETTLE      = csp_pkg::PIPE_LAT + 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_SCANS = 75;
    localparam int NUM_PHASES  = 6;

    // One scan: counts and untouched maxima, pad 0 is the leftmost.
    typedef struct packed {
        logic [csp_pkg::NUM_PADS-1:0][csp_pkg::COUNT_BITS-1:0] count;
        logic [csp_pkg::NUM_PADS-1:0][csp_pkg::COUNT_BITS-1:0] max;
    } t_scan;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [csp_pkg::THR_W-1:0] i_cfg_wr_data;

    csp_in_if  scan_if ();
    csp_out_if pos_if ();

    cap_slider_position DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_scan        (scan_if),
        .o_pos         (pos_if),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    // Predicted positions in transaction order, and the threshold the block holds.
    csp_pkg::t_result          expected_positions[$];
    logic [csp_pkg::THR_W-1:0] model_threshold = csp_pkg::THRESH_RESET;

    int  n_errors     = 0;
    int  n_scans      = 0;
    int  n_checked    = 0;
    int  n_touched    = 0;
    int  n_thresholds = 0;
    int  cycle_count  = 0;
    int  sink_hold    = 0;
    bit  source_idles = 1'b1;
    bit  sink_stalls  = 1'b1;

    // Clock, 8 ns period.
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Idle length: mostly none, some short, a few long.
    function automatic int pick_gap(input bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Normalize every pad, choose the deepest touched pad and interpolate
    // with its two neighbors; virtual pads past both ends sit at 255.
    function automatic csp_pkg::t_result predict_position(
        input t_scan s,
        input logic [csp_pkg::THR_W-1:0] thr);
        int               lvl [csp_pkg::NUM_PADS+2];
        int               best;
        int               pick;
        int               den;
        int               lo_term;
        int               hi_term;
        int               pos;
        csp_pkg::t_result r;
        best = (int'(thr) > FULL) ? FULL : int'(thr);
        pick = -1;
        lvl[0] = EDGE;
        lvl[csp_pkg::NUM_PADS+1] = EDGE;
        for (int i = 0; i < csp_pkg::NUM_PADS; i++) begin
            if (s.max[i] == '0) begin
                lvl[i+1] = FULL;
            end else begin
                lvl[i+1] = (int'(s.count[i]) << 8) / int'(s.max[i]);
                if (lvl[i+1] > FULL) lvl[i+1] = FULL;
            end
            if (lvl[i+1] < best) begin
                best = lvl[i+1];
                pick = i;
            end
        end
        r.touched  = 1'b0;
        r.position = '0;
        if (pick >= 0) begin
            den     = FULL - best;
            lo_term = ((FULL - lvl[pick]) << 3) / den;
            hi_term = ((FULL - lvl[pick+2]) << 3) / den;
            pos     = pick * 16 - lo_term + hi_term;
            if (pos < 0) pos = 0;
            if (pos > csp_pkg::POS_TOP) pos = csp_pkg::POS_TOP;
            r.touched  = 1'b1;
            r.position = csp_pkg::POS_W'(pos);
        end
        return r;
    endfunction

    // One line per mismatch, and a count of them.
    task automatic report_mismatch(input string what, input int want, input int got);
        $display("[%0t] MISMATCH %s: expected %0d, got %0d (result %0d)",
                 $realtime, what, want, got, n_checked);
        n_errors++;
    endtask

    // Offer one scan until it is taken, record its prediction, then maybe idle.
    task automatic send_scan(input t_scan s);
        csp_pkg::t_result want;
        int               gap;
        scan_if.valid      <= 1'b1;
        scan_if.pad0_count <= s.count[0];
        scan_if.pad1_count <= s.count[1];
        scan_if.pad2_count <= s.count[2];
        scan_if.pad3_count <= s.count[3];
        scan_if.pad0_max   <= s.max[0];
        scan_if.pad1_max   <= s.max[1];
        scan_if.pad2_max   <= s.max[2];
        scan_if.pad3_max   <= s.max[3];
        do @(posedge i_clk); while (scan_if.ready !== 1'b1);
        want = predict_position(s, model_threshold);
        expected_positions.push_back(want);
        n_scans++;
        if (want.touched) n_touched++;
        gap = pick_gap(source_idles);
        if (gap > 0) begin
            scan_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Directed scan from explicit counts and maxima.
    task automatic send_pads(input int c0, input int c1, input int c2, input int c3,
                             input int m0, input int m1, input int m2, input int m3);
        t_scan s;
        s.count[0] = csp_pkg::COUNT_BITS'(c0);
        s.count[1] = csp_pkg::COUNT_BITS'(c1);
        s.count[2] = csp_pkg::COUNT_BITS'(c2);
        s.count[3] = csp_pkg::COUNT_BITS'(c3);
        s.max[0]   = csp_pkg::COUNT_BITS'(m0);
        s.max[1]   = csp_pkg::COUNT_BITS'(m1);
        s.max[2]   = csp_pkg::COUNT_BITS'(m2);
        s.max[3]   = csp_pkg::COUNT_BITS'(m3);
        send_scan(s);
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic wait_for_results();
        scan_if.valid <= 1'b0;
        while (expected_positions.size() != 0) @(posedge i_clk);
        repeat (csp_pkg::PIPE_LAT + 2) @(posedge i_clk);
    endtask

    // Threshold writes happen only with the pipeline empty.
    task automatic write_threshold(input logic [csp_pkg::THR_W-1:0] thr);
        wait_for_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= thr;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        model_threshold = thr;
        n_thresholds++;
    endtask

    // Mostly finger-like scans, then fully random counts, then odd pad states.
    function automatic t_scan make_random_scan();
        t_scan s;
        int    kind;
        int    finger;
        int    lvl;
        int    m;
        int    c;
        kind   = $urandom_range(0, 99);
        finger = $urandom_range(0, csp_pkg::NUM_PADS - 1);
        for (int i = 0; i < csp_pkg::NUM_PADS; i++) begin
            if (kind < 65) begin
                m = ($urandom_range(0, 9) == 0) ? int'($urandom & 16'hFFFF)
                                                : $urandom_range(256, 65535);
                lvl = $urandom_range(230, 270);
                if (i == finger) lvl = $urandom_range(0, 240);
                else if ((i == finger - 1 || i == finger + 1) && $urandom_range(0, 1))
                    lvl = $urandom_range(100, 256);
                c = (m * lvl) >> 8;
                if (c > 65535) c = 65535;
                s.max[i]   = csp_pkg::COUNT_BITS'(m);
                s.count[i] = csp_pkg::COUNT_BITS'(c);
            end else if (kind < 85) begin
                s.max[i]   = csp_pkg::COUNT_BITS'($urandom);
                s.count[i] = csp_pkg::COUNT_BITS'($urandom);
            end else begin
                s.max[i]   = csp_pkg::COUNT_BITS'($urandom);
                s.count[i] = csp_pkg::COUNT_BITS'($urandom);
                case ($urandom_range(0, 4))
                    0: s.max[i]   = '0;
                    1: s.count[i] = '1;
                    2: s.max[i]   = '1;
                    3: s.count[i] = s.max[i];
                    default: s.count[i] = '0;
                endcase
            end
        end
        return s;
    endfunction

    // Scans at the reset threshold: untouched, saturated, ties, every pad.
    task automatic test_reset_threshold();
        send_pads(1000, 1000, 1000, 1000, 1000, 1000, 1000, 1000);
        send_pads(0, 0, 0, 0, 0, 0, 0, 0);
        send_pads(65535, 65535, 65535, 65535, 1, 1, 1, 1);
        send_pads(0, 0, 0, 0, 65535, 65535, 65535, 65535);
        send_pads(65535, 32768, 65535, 0, 65535, 65535, 65535, 65535);
        send_pads(256, 128, 128, 256, 256, 256, 256, 256);
        send_pads(235, 256, 256, 256, 256, 256, 256, 256);
        send_pads(256, 256, 256, 236, 256, 256, 256, 256);
        for (int i = 0; i < csp_pkg::NUM_PADS; i++) begin
            send_pads(i == 0 ? 64 : (i == 1 ? 192 : 256),
                      i == 1 ? 64 : ((i == 0 || i == 2) ? 192 : 256),
                      i == 2 ? 64 : ((i == 1 || i == 3) ? 192 : 256),
                      i == 3 ? 64 : (i == 2 ? 192 : 256),
                      256, 256, 256, 256);
        end
        send_pads(0, 256, 256, 0, 256, 256, 256, 256);
    endtask

    // Threshold at zero, one, just under full scale, and the top end where it saturates.
    task automatic test_threshold_extremes();
        write_threshold('0);
        send_pads(0, 0, 0, 0, 100, 100, 100, 100);
        write_threshold(csp_pkg::THR_W'(1));
        send_pads(0, 0, 0, 0, 100, 100, 100, 100);
        send_pads(1, 0, 0, 0, 100, 100, 100, 100);
        write_threshold(csp_pkg::THR_W'(FULL));
        send_pads(255, 256, 256, 256, 256, 256, 256, 256);
        send_pads(256, 256, 256, 255, 256, 256, 256, 256);
        send_pads(256, 255, 256, 256, 256, 256, 256, 256);
        write_threshold('1);
        send_pads(255, 256, 256, 256, 256, 256, 256, 256);
        send_pads(256, 256, 256, 255, 256, 256, 256, 256);
        send_pads(65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535);
        write_threshold(csp_pkg::THR_W'(EDGE));
        send_pads(256, 256, 255, 256, 256, 256, 256, 256);
        send_pads(256, 256, 254, 256, 256, 256, 256, 256);
    endtask

    // Random scans in phases, each under its own threshold; one phase runs
    // with no idling on either side.
    task automatic test_random_scans();
        logic [csp_pkg::THR_W-1:0] thr;
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: thr = csp_pkg::THRESH_RESET;
                1: thr = csp_pkg::THR_W'(FULL);
                2: thr = csp_pkg::THR_W'($urandom_range(1, 255));
                3: thr = '1;
                4: thr = csp_pkg::THR_W'($urandom_range(257, 510));
                default: thr = csp_pkg::THR_W'($urandom_range(100, 250));
            endcase
            write_threshold(thr);
            source_idles = (p != 2);
            sink_stalls  = (p != 2);
            for (int n = 0; n < PHASE_SCANS; n++) send_scan(make_random_scan());
        end
        source_idles = 1'b1;
        sink_stalls  = 1'b1;
    endtask

    // Result side: random stalls on ready.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pos_if.ready <= 1'b0;
        end else if (sink_hold > 0) begin
            sink_hold--;
            pos_if.ready <= 1'b0;
        end else begin
            sink_hold = pick_gap(sink_stalls);
            pos_if.ready <= (sink_hold == 0);
        end
    end

    // Compare each result transaction with the oldest prediction.
    always @(posedge i_clk) begin
        csp_pkg::t_result want;
        if (i_rst_n && pos_if.valid === 1'b1 && pos_if.ready === 1'b1) begin
            if (expected_positions.size() == 0) begin
                report_mismatch("result with nothing expected, position", 0,
                                int'(pos_if.position));
            end else begin
                want = expected_positions.pop_front();
                if (pos_if.touched !== want.touched)
                    report_mismatch("touched", int'(want.touched), int'(pos_if.touched));
                if (pos_if.position !== want.position)
                    report_mismatch("position", int'(want.position), int'(pos_if.position));
            end
            n_checked++;
        end
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_positions.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Test sequence; every input starts at a known value.
    initial begin
        i_rst_n            = 1'b0;
        i_cfg_wr_en        = 1'b0;
        i_cfg_wr_data      = '0;
        scan_if.valid      = 1'b0;
        scan_if.pad0_count = '0;
        scan_if.pad1_count = '0;
        scan_if.pad2_count = '0;
        scan_if.pad3_count = '0;
        scan_if.pad0_max   = '0;
        scan_if.pad1_max   = '0;
        scan_if.pad2_max   = '0;
        scan_if.pad3_max   = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_threshold();
        test_threshold_extremes();
        test_random_scans();
        wait_for_results();
        repeat (SETTLE) @(posedge i_clk);
        if (expected_positions.size() != 0)
            report_mismatch("results never delivered", 0, expected_positions.size());
        $display("Sent %0d scans under %0d threshold settings; %0d results checked.",
                 n_scans, n_thresholds + 1, n_checked);
        $display("%0d of the results reported a touch; %0d mismatches.",
                 n_touched, n_errors);
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
